// ===== sv/hsa_pkg.sv =====
// Shared constants and types for the heap sort block.
package hsa_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int DATA_W       = 32;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_RD,
		ST_BLD_LD,
		ST_RDL,
		ST_RDR,
		ST_CMP,
		ST_EX_RD0,
		ST_EX_RDE,
		ST_EX_WR,
		ST_EM_RD,
		ST_EM_LD
	} hsa_state_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} hsa_mem_ctl_t;

endpackage

// ===== sv/heap_sort_ascending.sv =====
// Heap sort block: collects a set of signed words, then streams them out in ascending order.
//
// Values arrive one transfer per cycle and are stored in arrival order; the transfer with
// tlast closes the set. Up to MAX_ELEMENTS values are kept; further values are dropped and
// every result of that set carries the overflow flag in tuser. After the closing transfer
// the block accepts nothing until the last result has been loaded into the output register.
// All work runs through one element memory with a single read and a single write port and a
// registered read, so each sift level takes a left read, a right read, and a compare and write;
// each extraction reads the root and the last entry and writes the root to the end, and each
// result is read and then loaded into the output register. The sorted results appear smallest
// first, the greatest one with tlast set.
module heap_sort_ascending (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hsa_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
	input  logic                       s_tlast,  // is_last
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hsa_pkg::DATA_W-1:0] m_tdata,  // [31:0] sorted_value
	output logic                       m_tlast,  // end_of_run
	output logic                       m_tuser   // [0] overflow
);
	import hsa_pkg::*;

	hsa_state_t state_q, state_d;

	logic [DATA_W-1:0] store_q [MAX_ELEMENTS];
	logic [DATA_W-1:0] rdata_q;
	hsa_mem_ctl_t      mem;

	logic [CNT_W-1:0]  cnt_q;
	logic              dropped_q;
	logic              build_q;
	logic [IDX_W-1:0]  last_q;
	logic [IDX_W-1:0]  bi_q;
	logic [IDX_W-1:0]  node_q;
	logic [IDX_W-1:0]  k_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] lval_q;
	logic              has_r_q;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	logic              s_xfer;
	logic              full;
	logic [CNT_W-1:0]  cnt_new;
	logic [IDX_W:0]    left;
	logic [IDX_W+1:0]  right;
	logic              left_ok;
	logic              right_ok;
	logic              r_gt;
	logic [DATA_W-1:0] best_val;
	logic [IDX_W-1:0]  best_idx;
	logic              move;
	logic              sift_done;
	logic              em_last;
	logic              out_free;
	logic              out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(MAX_ELEMENTS));
	assign cnt_new  = full ? cnt_q : cnt_q + CNT_W'(1);

	assign left     = {node_q, 1'b1};
	assign right    = {1'b0, node_q, 1'b0} + (IDX_W+2)'(2);
	assign left_ok  = left <= (IDX_W+1)'(last_q);
	assign right_ok = right <= (IDX_W+2)'(last_q);

	assign r_gt      = has_r_q && ($signed(rdata_q) > $signed(lval_q));
	assign best_val  = r_gt ? rdata_q : lval_q;
	assign best_idx  = r_gt ? right[IDX_W-1:0] : left[IDX_W-1:0];
	assign move      = $signed(best_val) > $signed(val_q);
	assign sift_done = ((state_q == ST_RDL) && !left_ok) || ((state_q == ST_CMP) && !move);

	assign em_last  = (k_q == IDX_W'(cnt_q - CNT_W'(1)));
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == ST_EM_LD) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer && s_tlast) begin
					state_d = (cnt_new < CNT_W'(2)) ? ST_EM_RD : ST_BLD_RD;
				end
			end
			ST_BLD_RD: state_d = ST_BLD_LD;
			ST_BLD_LD: state_d = ST_RDL;
			ST_RDL:    state_d = left_ok ? ST_RDR : ST_IDLE;
			ST_RDR:    state_d = ST_CMP;
			ST_CMP:    state_d = move ? ST_RDL : ST_IDLE;
			ST_EX_RD0: state_d = ST_EX_RDE;
			ST_EX_RDE: state_d = ST_EX_WR;
			ST_EX_WR:  state_d = ST_RDL;
			ST_EM_RD:  state_d = ST_EM_LD;
			ST_EM_LD: begin
				if (out_free) begin
					state_d = em_last ? ST_IDLE : ST_EM_RD;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
		if (sift_done) begin
			if (build_q) begin
				state_d = (bi_q == '0) ? ST_EX_RD0 : ST_BLD_RD;
			end else begin
				state_d = (last_q == '0) ? ST_EM_RD : ST_EX_RD0;
			end
		end
	end

	// memory port control; accesses never hit the same entry in overlapping cycles
	always_comb begin
		mem = '{we: 1'b0, waddr: '0, wdata: '0, re: 1'b0, raddr: '0};
		case (state_q)
			ST_IDLE: begin
				mem.we    = s_xfer && !full;
				mem.waddr = cnt_q[IDX_W-1:0];
				mem.wdata = s_tdata;
			end
			ST_BLD_RD: begin
				mem.re    = 1'b1;
				mem.raddr = bi_q;
			end
			ST_RDL: begin
				mem.re    = left_ok;
				mem.raddr = left[IDX_W-1:0];
				mem.we    = !left_ok;
				mem.waddr = node_q;
				mem.wdata = val_q;
			end
			ST_RDR: begin
				mem.re    = right_ok;
				mem.raddr = right[IDX_W-1:0];
			end
			ST_CMP: begin
				mem.we    = 1'b1;
				mem.waddr = node_q;
				mem.wdata = move ? best_val : val_q;
			end
			ST_EX_RD0: begin
				mem.re    = 1'b1;
				mem.raddr = '0;
			end
			ST_EX_RDE: begin
				mem.re    = 1'b1;
				mem.raddr = last_q;
			end
			ST_EX_WR: begin
				mem.we    = 1'b1;
				mem.waddr = last_q;
				mem.wdata = lval_q;
			end
			ST_EM_RD: begin
				mem.re    = 1'b1;
				mem.raddr = k_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem.we) begin
			store_q[mem.waddr] <= mem.wdata;
		end
		if (mem.re) begin
			rdata_q <= store_q[mem.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dropped_q  <= 1'b0;
			build_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_xfer) begin
				cnt_q <= cnt_new;
				if (full) begin
					dropped_q <= 1'b1;
				end
				build_q <= 1'b1;
			end
			if (sift_done && build_q && bi_q == '0) begin
				build_q <= 1'b0;
			end
			if (out_load && em_last) begin
				cnt_q     <= '0;
				dropped_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				last_q <= IDX_W'(cnt_new - CNT_W'(1));
				bi_q   <= IDX_W'((cnt_new - CNT_W'(2)) >> 1);
				k_q    <= '0;
			end
			ST_BLD_RD: node_q <= bi_q;
			ST_BLD_LD: val_q  <= rdata_q;
			ST_RDR: begin
				lval_q  <= rdata_q;
				has_r_q <= right_ok;
			end
			ST_CMP: begin
				if (move) begin
					node_q <= best_idx;
				end
			end
			ST_EX_RDE: lval_q <= rdata_q;
			ST_EX_WR: begin
				val_q  <= rdata_q;
				node_q <= '0;
				last_q <= last_q - IDX_W'(1);
			end
			ST_EM_LD: begin
				if (out_free) begin
					k_q <= k_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
		if (sift_done && build_q && bi_q != '0) begin
			bi_q <= bi_q - IDX_W'(1);
		end
		if (out_load) begin
			m_tdata_q <= rdata_q;
			m_tlast_q <= em_last;
			m_tuser_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// sorting writes stay inside the stored set
	a_wr_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(mem.we && state_q != ST_IDLE) |-> (CNT_W'(mem.waddr) < cnt_q))
		else $error("sort write outside stored set");

	// a sift never walks past the end of the heap
	a_node_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RDL || state_q == ST_RDR || state_q == ST_CMP) |-> (node_q <= last_q))
		else $error("sift node beyond heap end");

	// loading the final result closes the set
	a_run_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && em_last) |=> (cnt_q == '0 && !dropped_q && state_q == ST_IDLE && m_tlast))
		else $error("set not closed after final result");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the heap sort block: directed and random sets through the stream ports.
typedef struct {
	logic signed [hsa_pkg::DATA_W-1:0] value;
	logic                              last;
	logic                              ovf;
} sorted_item_t;

class sort_scoreboard;
	logic signed [hsa_pkg::DATA_W-1:0] held[$];
	bit                                dropped;
	sorted_item_t                      sorted_q[$];
	int                                errors;

	function int pending();
		return sorted_q.size();
	endfunction

	function void note_input(logic signed [hsa_pkg::DATA_W-1:0] v, logic l);
		logic signed [hsa_pkg::DATA_W-1:0] ordered[$];
		sorted_item_t                      item;
		int                                pos;
		if (held.size() < hsa_pkg::MAX_ELEMENTS) begin
			held.push_back(v);
		end else begin
			dropped = 1'b1;
		end
		if (l) begin
			foreach (held[i]) begin
				pos = 0;
				while (pos < ordered.size() && ordered[pos] <= held[i])
					pos++;
				ordered.insert(pos, held[i]);
			end
			foreach (ordered[k]) begin
				item.value = ordered[k];
				item.last  = (k == ordered.size() - 1);
				item.ovf   = dropped;
				sorted_q.push_back(item);
			end
			held.delete();
			dropped = 1'b0;
		end
	endfunction

	task report(string msg);
		errors++;
		$display("ERROR: %s", msg);
	endtask

	task check_result(logic signed [hsa_pkg::DATA_W-1:0] v, logic l, logic ovf);
		sorted_item_t item;
		if (sorted_q.size() == 0) begin
			report($sformatf("unexpected result value=%0d last=%0b ovf=%0b", v, l, ovf));
		end else begin
			item = sorted_q.pop_front();
			if (v !== item.value)
				report($sformatf("value %0d, want %0d", v, item.value));
			if (l !== item.last)
				report($sformatf("tlast %0b, want %0b (value %0d)", l, item.last, item.value));
			if (ovf !== item.ovf)
				report($sformatf("overflow %0b, want %0b (value %0d)", ovf, item.ovf, item.value));
		end
	endtask
endclass

module tb_top;
	import hsa_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int ITEM_TARGET = 360;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic              s_tlast;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	sort_scoreboard sb;
	bit             steady;
	int             idle_cycles;
	int             items_sent;

	heap_sort_ascending dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= (steady || !arst_n) ? 1'b1 : ($urandom_range(99) >= 22);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	task send_item(input logic [DATA_W-1:0] v, input logic l);
		if (!steady) begin
			while ($urandom_range(99) < 22) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task send_set(input logic [DATA_W-1:0] vals[$]);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function logic [DATA_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return $urandom_range(16) - 8;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [DATA_W-1:0] vals[$];
		int                set_idx;
		int                size;
		int                r;
		sb          = new();
		steady      = 1'b0;
		idle_cycles = 0;
		items_sent  = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_set('{VAL_MIN});
		send_set('{VAL_MAX, VAL_MIN});
		send_set('{32'h0, 32'hffff_ffff, 32'h1, VAL_MAX, VAL_MIN, 32'hffff_ffff,
			32'h5555_5555, 32'haaaa_aaaa});
		send_set('{32'd5, 32'd5, 32'd5, 32'd5});
		drain();
		send_set('{32'd4, 32'd3, 32'd2, 32'd1, 32'd0, 32'hffff_ffff});
		drain();

		set_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(99);
			if (set_idx == 0)
				size = MAX_ELEMENTS + 3;
			else if (set_idx == 1)
				size = MAX_ELEMENTS;
			else if (r < 6)
				size = $urandom_range(MAX_ELEMENTS + 4, MAX_ELEMENTS + 1);
			else if (r < 12)
				size = $urandom_range(MAX_ELEMENTS, MAX_ELEMENTS - 4);
			else
				size = $urandom_range(12, 1);
			steady = (set_idx >= 3 && set_idx < 7);
			vals.delete();
			repeat (size)
				vals.push_back(rand_value());
			send_set(vals);
			if (set_idx == 2 || $urandom_range(3) == 0)
				drain();
			set_idx++;
		end
		steady = 1'b0;
		drain();
		repeat (40) @(negedge clk);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
